// File: rtl/core/psg_seq_pkg.sv
// Shared types, constants and table functions for the song sequencer.
`default_nettype none
package psg_seq_pkg;

  localparam int VOICES = 4;

  // Reset values of the configuration registers
  localparam logic [5:0] DECAY_PERIOD_RST     = 6'd6;
  localparam logic [3:0] SOFT_NOISE_LEVEL_RST = 4'd4;
  localparam logic [7:0] START_DELAY_RST      = 8'd50;
  localparam logic [3:0] ATTEN_SILENT         = 4'd15;

  // Configuration register indexes
  localparam logic [1:0] CFG_DECAY_PERIOD     = 2'd0;
  localparam logic [1:0] CFG_SOFT_NOISE_LEVEL = 2'd1;
  localparam logic [1:0] CFG_START_DELAY      = 2'd2;

  // Command byte bits 7:6
  typedef enum logic [1:0] {
    CMD_NOTE  = 2'b00,
    CMD_DELAY = 2'b01,
    CMD_NOISE = 2'b10,
    CMD_END   = 2'b11
  } cmd_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] command_byte;
    logic [9:0] note_period;
  } in_item_t;

  typedef struct packed {
    logic       has_write;
    logic [7:0] chip_byte;
    logic       led_update;
    logic [1:0] led_select;
    logic [7:0] led_level;
    logic       wants_command;
    logic       song_over;
    logic       last_of_run;
  } out_item_t;

  // One result before the per-input flags are attached
  typedef struct packed {
    logic       has_write;
    logic [7:0] chip_byte;
    logic       led_update;
    logic [1:0] led_select;
    logic [7:0] led_level;
  } slot_t;

  // All results of one input, handed from the core to the output buffer
  typedef struct packed {
    slot_t [VOICES-1:0] slots;
    logic [1:0]         last_idx;
    logic               wants_command;
    logic               song_over;
  } bundle_t;

  typedef struct packed {
    logic [VOICES-1:0][3:0] atten;
    logic [5:0]             decay_count;
    logic [7:0]             noise_count;
    logic [2:0]             noise_step_period;
    logic [7:0]             wait_count;
    logic                   awaiting_command;
    logic                   finished;
  } seq_state_t;

  function automatic logic [7:0] fade_level(input logic [3:0] atten);
    logic [7:0] lvl;
    case (atten)
      4'd0:    lvl = 8'd255;
      4'd1:    lvl = 8'd179;
      4'd2:    lvl = 8'd125;
      4'd3:    lvl = 8'd88;
      4'd4:    lvl = 8'd61;
      4'd5:    lvl = 8'd43;
      4'd6:    lvl = 8'd30;
      4'd7:    lvl = 8'd21;
      4'd8:    lvl = 8'd15;
      4'd9:    lvl = 8'd10;
      4'd10:   lvl = 8'd7;
      4'd11:   lvl = 8'd5;
      4'd12:   lvl = 8'd4;
      4'd13:   lvl = 8'd2;
      4'd14:   lvl = 8'd1;
      default: lvl = 8'd0;
    endcase
    return lvl;
  endfunction

  // Chip attenuation write: 1 vv 1 aaaa
  function automatic logic [7:0] atten_byte(input logic [1:0] voice, input logic [3:0] atten);
    return {1'b1, voice, 1'b1, atten};
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/psg_seq_core.sv
// Next-state and result logic for one input item.
`default_nettype none
module psg_seq_core (
  input  wire psg_seq_pkg::seq_state_t st,
  input  wire psg_seq_pkg::in_item_t   item,
  input  wire logic [5:0]              decay_period,
  input  wire logic [3:0]              soft_noise_level,
  output psg_seq_pkg::seq_state_t      st_next,
  output psg_seq_pkg::bundle_t         bundle
);

  logic [5:0]                          dc_inc;
  logic [7:0]                          nc_inc;
  logic                                decay_hit;
  logic                                noise_hit;
  logic [psg_seq_pkg::VOICES-1:0]      step;
  logic [psg_seq_pkg::VOICES-1:0][3:0] atten_inc;
  logic [2:0]                          n;
  logic [1:0]                          sel;
  logic [3:0]                          best;
  logic [3:0]                          noise_start_level;
  psg_seq_pkg::cmd_t                   cmd;

  assign dc_inc    = st.decay_count + 6'd1;
  assign nc_inc    = st.noise_count + 8'd1;
  assign decay_hit = (dc_inc == decay_period);
  assign noise_hit = (nc_inc == {5'd0, st.noise_step_period});
  assign cmd       = psg_seq_pkg::cmd_t'(item.command_byte[7:6]);
  assign noise_start_level = item.command_byte[5] ? soft_noise_level : 4'd0;

  always_comb begin
    for (int v = 0; v < psg_seq_pkg::VOICES; v++) begin
      atten_inc[v] = st.atten[v] + 4'd1;
      step[v] = ((v == psg_seq_pkg::VOICES - 1) ? noise_hit : decay_hit) &&
                (st.atten[v] != psg_seq_pkg::ATTEN_SILENT);
    end
  end

  // Quietest tone voice, lowest index on a tie
  always_comb begin
    sel  = 2'd0;
    best = st.atten[0];
    if (st.atten[1] > best) begin
      sel  = 2'd1;
      best = st.atten[1];
    end
    if (st.atten[2] > best) begin
      sel = 2'd2;
    end
  end

  always_comb begin
    st_next       = st;
    bundle.slots  = '0;
    n             = 3'd0;
    if (!st.finished) begin
      if (!item.opcode) begin
        st_next.decay_count = decay_hit ? 6'd0 : dc_inc;
        st_next.noise_count = noise_hit ? 8'd0 : nc_inc;
        for (int v = 0; v < psg_seq_pkg::VOICES; v++) begin
          if (step[v]) begin
            st_next.atten[v]               = atten_inc[v];
            bundle.slots[n[1:0]].has_write  = 1'b1;
            bundle.slots[n[1:0]].chip_byte  = psg_seq_pkg::atten_byte(2'(v), atten_inc[v]);
            bundle.slots[n[1:0]].led_update = 1'b1;
            bundle.slots[n[1:0]].led_select = 2'(v);
            bundle.slots[n[1:0]].led_level  = psg_seq_pkg::fade_level(atten_inc[v]);
            n = n + 3'd1;
          end
        end
        if (st.wait_count != 8'd0) begin
          st_next.wait_count = st.wait_count - 8'd1;
        end else begin
          st_next.awaiting_command = 1'b1;
        end
      end else if (st.awaiting_command) begin
        case (cmd)
          psg_seq_pkg::CMD_NOTE: begin
            st_next.atten[sel]          = 4'd0;
            bundle.slots[0].has_write   = 1'b1;
            bundle.slots[0].chip_byte   = {1'b1, sel, 1'b0, item.note_period[3:0]};
            bundle.slots[1].has_write   = 1'b1;
            bundle.slots[1].chip_byte   = {2'b00, item.note_period[9:4]};
            bundle.slots[2].has_write   = 1'b1;
            bundle.slots[2].chip_byte   = psg_seq_pkg::atten_byte(sel, 4'd0);
            n = 3'd3;
          end
          psg_seq_pkg::CMD_DELAY: begin
            st_next.wait_count = {2'b00, item.command_byte[5:0]};
            if (item.command_byte[5:0] != 6'd0) begin
              st_next.awaiting_command = 1'b0;
            end
          end
          psg_seq_pkg::CMD_NOISE: begin
            st_next.noise_step_period = {1'b0, item.command_byte[4:3]} + 3'd1;
            st_next.noise_count       = 8'd0;
            st_next.atten[3]          = noise_start_level;
            bundle.slots[0].has_write = 1'b1;
            bundle.slots[0].chip_byte = {5'b11100, item.command_byte[2:0]};
            bundle.slots[1].has_write = 1'b1;
            bundle.slots[1].chip_byte = psg_seq_pkg::atten_byte(2'd3, noise_start_level);
            n = 3'd2;
          end
          default: begin
            // end of song: silence every voice and blank its LED
            for (int v = 0; v < psg_seq_pkg::VOICES; v++) begin
              st_next.atten[v]           = psg_seq_pkg::ATTEN_SILENT;
              bundle.slots[v].has_write  = 1'b1;
              bundle.slots[v].chip_byte  =
                psg_seq_pkg::atten_byte(2'(v), psg_seq_pkg::ATTEN_SILENT);
              bundle.slots[v].led_update = 1'b1;
              bundle.slots[v].led_select = 2'(v);
            end
            st_next.finished         = 1'b1;
            st_next.awaiting_command = 1'b0;
            n = 3'd4;
          end
        endcase
      end
    end
    // no write: a single empty result still goes out
    bundle.last_idx      = (n == 3'd0) ? 2'd0 : 2'(n - 3'd1);
    bundle.wants_command = st_next.awaiting_command;
    bundle.song_over     = st_next.finished;
  end

endmodule
`default_nettype wire

// File: rtl/core/psg_seq_obuf.sv
// Result buffer: holds the results of one input and hands them out one a cycle while out_ready is high.
`default_nettype none
module psg_seq_obuf (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         load,
  input  wire psg_seq_pkg::bundle_t   bundle_in,
  output logic                        can_load,
  output logic                        out_valid,
  input  wire                         out_ready,
  output psg_seq_pkg::out_item_t      out_data
);

  logic                 valid;
  logic [1:0]           idx;
  psg_seq_pkg::bundle_t held;
  logic                 last;
  psg_seq_pkg::slot_t   cur;

  assign last      = (idx == held.last_idx);
  assign cur       = held.slots[idx];
  assign out_valid = valid;
  assign can_load  = !valid || (out_ready && last);

  assign out_data.has_write     = cur.has_write;
  assign out_data.chip_byte     = cur.chip_byte;
  assign out_data.led_update    = cur.led_update;
  assign out_data.led_select    = cur.led_select;
  assign out_data.led_level     = cur.led_level;
  assign out_data.wants_command = held.wants_command;
  assign out_data.song_over     = held.song_over;
  assign out_data.last_of_run   = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 2'd0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= 2'd0;
    end else if (valid && out_ready) begin
      if (last) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= bundle_in;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/psg_song_sequencer_unit.sv
// Top level of the song sequencer: input register, state, config and result buffer.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------
//  in       | in_valid / in_ready   | in_data  (opcode, command_byte, note_period)
//  out      | out_valid / out_ready | out_data (one result per transfer)
//  cfg      | cfg_write             | cfg_index, cfg_data
//
// Each input gives one to four results; the result buffer sends one per cycle
// while out_ready is high, and the next item is taken in the same cycle as the last
// result of the previous one goes out. Results leave from the result buffer,
// loaded from the input register. Reset is synchronous. A stalled output holds
// its result and, once the input register is full, the input stalls too.
`default_nettype none
module psg_song_sequencer_unit (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire psg_seq_pkg::in_item_t  in_data,
  output logic                        out_valid,
  input  wire                         out_ready,
  output psg_seq_pkg::out_item_t      out_data,
  input  wire                         cfg_write,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [7:0]             cfg_data
);

  logic                    in_full;
  psg_seq_pkg::in_item_t   in_hold;
  logic                    advance;
  logic                    buf_can_load;
  psg_seq_pkg::seq_state_t st;
  psg_seq_pkg::seq_state_t st_next;
  psg_seq_pkg::bundle_t    bundle;
  logic [5:0]              decay_period;
  logic [3:0]              soft_noise_level;

  assign advance  = in_full && buf_can_load;
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_hold <= in_data;
    end
  end

  // start delay only matters through the countdown it loads, kept in st
  always_ff @(posedge clk) begin
    if (rst) begin
      decay_period     <= psg_seq_pkg::DECAY_PERIOD_RST;
      soft_noise_level <= psg_seq_pkg::SOFT_NOISE_LEVEL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        psg_seq_pkg::CFG_DECAY_PERIOD:     decay_period     <= cfg_data[5:0];
        psg_seq_pkg::CFG_SOFT_NOISE_LEVEL: soft_noise_level <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.atten             <= {psg_seq_pkg::VOICES{psg_seq_pkg::ATTEN_SILENT}};
      st.decay_count       <= 6'd0;
      st.noise_count       <= 8'd0;
      st.noise_step_period <= 3'd0;
      st.wait_count        <= psg_seq_pkg::START_DELAY_RST;
      st.awaiting_command  <= 1'b0;
      st.finished          <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end else if (cfg_write && cfg_index == psg_seq_pkg::CFG_START_DELAY) begin
      // new start delay reloads the countdown, unless an input advances in the same cycle
      st.wait_count <= cfg_data;
    end
  end

  psg_seq_core u_core (
    .st               (st),
    .item             (in_hold),
    .decay_period     (decay_period),
    .soft_noise_level (soft_noise_level),
    .st_next          (st_next),
    .bundle           (bundle)
  );

  psg_seq_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .bundle_in (bundle),
    .can_load  (buf_can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: rtl/core/psg_seq_checker.sv
// Port-level checks for the song sequencer, bound to the top level.
`default_nettype none
module psg_seq_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        out_valid,
  input wire                        out_ready,
  input wire psg_seq_pkg::out_item_t out_data
);

  // stalled result must hold
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_over_not_waiting: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.song_over |-> !out_data.wants_command)
    else $error("song over while still asking for commands");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.has_write |-> out_data.last_of_run && !out_data.led_update)
    else $error("empty result not alone");

  a_over_sticks: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.song_over |=> !out_valid || out_data.song_over)
    else $error("song over cleared without reset");

endmodule

bind psg_song_sequencer_unit psg_seq_checker u_psg_seq_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the song sequencer top level.
module tb;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_CMD  = 1'b1;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam logic [3:0] LEVEL_SILENT = 4'd15;
  // Fade brightness per attenuation step, element 0 is loudest
  localparam logic [15:0][7:0] FADE_TBL = {8'd0, 8'd1, 8'd2, 8'd4, 8'd5, 8'd7, 8'd10, 8'd15,
                                           8'd21, 8'd30, 8'd43, 8'd61, 8'd88, 8'd125, 8'd179,
                                           8'd255};

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  psg_seq_pkg::in_item_t  in_data;
  logic                   out_valid;
  logic                   out_ready;
  psg_seq_pkg::out_item_t out_data;
  logic                   cfg_write;
  logic [1:0]             cfg_index;
  logic [7:0]             cfg_data;

  psg_song_sequencer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sequencer mirror state and registers
  logic [3:0] voice_level [0:3];
  logic [5:0] decay_ticks;
  logic [7:0] noise_ticks;
  logic [2:0] noise_period;
  logic [7:0] wait_ticks;
  logic       want_cmd;
  logic       song_done;
  logic [5:0] decay_period_reg;
  logic [3:0] soft_level_reg;
  logic [7:0] start_delay_reg;

  psg_seq_pkg::out_item_t run_results [$];
  psg_seq_pkg::out_item_t due_results [$];
  int         error_count = 0;
  bit         idling_on = 1'b1;
  int         hold_left = 0;

  task automatic reset_mirror();
    int i;
    for (i = 0; i < 4; i++) voice_level[i] = LEVEL_SILENT;
    decay_ticks      = '0;
    noise_ticks      = '0;
    noise_period     = '0;
    decay_period_reg = psg_seq_pkg::DECAY_PERIOD_RST;
    soft_level_reg   = psg_seq_pkg::SOFT_NOISE_LEVEL_RST;
    start_delay_reg  = psg_seq_pkg::START_DELAY_RST;
    wait_ticks       = start_delay_reg;
    want_cmd         = 1'b0;
    song_done        = 1'b0;
  endtask

  task automatic push_result(input logic wr, input logic [7:0] b, input logic led,
                             input logic [1:0] sel, input logic [7:0] lvl);
    psg_seq_pkg::out_item_t r;
    r = '0;
    r.has_write  = wr;
    r.chip_byte  = b;
    r.led_update = led;
    r.led_select = sel;
    r.led_level  = lvl;
    run_results.push_back(r);
  endtask

  task automatic step_level(input logic [1:0] v);
    if (voice_level[v] < LEVEL_SILENT) begin
      voice_level[v] = voice_level[v] + 4'd1;
      push_result(1'b1, {1'b1, v, 1'b1, voice_level[v]}, 1'b1, v, FADE_TBL[voice_level[v]]);
    end
  endtask

  // Works out the results of one accepted input and queues them
  task automatic advance_sequencer(input psg_seq_pkg::in_item_t it);
    logic [1:0] v;
    logic [3:0] lvl;
    logic [7:0] cb;
    int i;
    psg_seq_pkg::out_item_t r;
    run_results.delete();
    cb = it.command_byte;
    if (!song_done) begin
      if (it.opcode == OP_TICK) begin
        decay_ticks = decay_ticks + 6'd1;
        if (decay_ticks == decay_period_reg) begin
          decay_ticks = '0;
          for (i = 0; i < 3; i++) step_level(i[1:0]);
        end
        noise_ticks = noise_ticks + 8'd1;
        if (noise_ticks == {5'd0, noise_period}) begin
          noise_ticks = '0;
          step_level(2'd3);
        end
        if (wait_ticks != 8'd0) wait_ticks = wait_ticks - 8'd1;
        else want_cmd = 1'b1;
      end else if (want_cmd) begin
        case (psg_seq_pkg::cmd_t'(cb[7:6]))
          psg_seq_pkg::CMD_NOTE: begin
            // quietest tone voice, ties to the lowest index
            v = 2'd0;
            if (voice_level[1] > voice_level[v]) v = 2'd1;
            if (voice_level[2] > voice_level[v]) v = 2'd2;
            voice_level[v] = 4'd0;
            push_result(1'b1, {1'b1, v, 1'b0, it.note_period[3:0]}, 1'b0, 2'd0, 8'd0);
            push_result(1'b1, {2'b00, it.note_period[9:4]}, 1'b0, 2'd0, 8'd0);
            push_result(1'b1, {1'b1, v, 1'b1, 4'd0}, 1'b0, 2'd0, 8'd0);
          end
          psg_seq_pkg::CMD_DELAY: begin
            wait_ticks = {2'b00, cb[5:0]};
            if (cb[5:0] != 6'd0) want_cmd = 1'b0;
          end
          psg_seq_pkg::CMD_NOISE: begin
            noise_period = {1'b0, cb[4:3]} + 3'd1;
            noise_ticks  = '0;
            lvl = cb[5] ? soft_level_reg : 4'd0;
            voice_level[3] = lvl;
            push_result(1'b1, {5'b11100, cb[2:0]}, 1'b0, 2'd0, 8'd0);
            push_result(1'b1, {4'hF, lvl}, 1'b0, 2'd0, 8'd0);
          end
          psg_seq_pkg::CMD_END: begin
            for (i = 0; i < 4; i++) begin
              voice_level[i] = LEVEL_SILENT;
              push_result(1'b1, {1'b1, i[1:0], 1'b1, LEVEL_SILENT}, 1'b1, i[1:0], 8'd0);
            end
            song_done = 1'b1;
            want_cmd  = 1'b0;
          end
          default: ;
        endcase
      end
    end
    if (run_results.size() == 0) push_result(1'b0, 8'd0, 1'b0, 2'd0, 8'd0);
    for (i = 0; i < run_results.size(); i++) begin
      r = run_results[i];
      r.wants_command = want_cmd;
      r.song_over     = song_done;
      r.last_of_run   = (i == run_results.size() - 1);
      due_results.push_back(r);
    end
  endtask

  // Register write; only called with the block idle
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      psg_seq_pkg::CFG_DECAY_PERIOD:     decay_period_reg = data[5:0];
      psg_seq_pkg::CFG_SOFT_NOISE_LEVEL: soft_level_reg = data[3:0];
      psg_seq_pkg::CFG_START_DELAY: begin
        start_delay_reg = data;
        wait_ticks      = start_delay_reg;
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input psg_seq_pkg::in_item_t it);
    int gap;
    if (idling_on && $urandom_range(0, 99) < 15) begin
      gap = $urandom_range(1, 16);
      repeat (gap) @(negedge clk);
    end
    in_data  = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_sequencer(it);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drain();
    while (due_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic psg_seq_pkg::in_item_t tick_item();
    psg_seq_pkg::in_item_t it;
    it.opcode       = OP_TICK;
    it.command_byte = 8'($urandom);
    it.note_period  = 10'($urandom);
    return it;
  endfunction

  function automatic psg_seq_pkg::in_item_t cmd_item(input psg_seq_pkg::cmd_t c,
                                                     input logic [5:0] low);
    psg_seq_pkg::in_item_t it;
    it.opcode       = OP_CMD;
    it.command_byte = {c, low};
    it.note_period  = 10'($urandom);
    return it;
  endfunction

  function automatic logic [5:0] delay_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 6'd0;
    if (r < 95) return 6'($urandom_range(1, 6));
    return 6'($urandom_range(7, 63));
  endfunction

  // Mostly well-formed command streams; junk bytes while not awaiting are not counted
  task automatic run_random(input int count, input int tick_pct);
    int done;
    int r;
    bit counts;
    psg_seq_pkg::in_item_t it;
    done = 0;
    while (done < count) begin
      counts = 1'b1;
      if (want_cmd && $urandom_range(0, 99) >= tick_pct) begin
        r = $urandom_range(0, 99);
        if (r < 45) it = cmd_item(psg_seq_pkg::CMD_NOTE, 6'($urandom_range(0, 63)));
        else if (r < 70) it = cmd_item(psg_seq_pkg::CMD_NOISE, 6'($urandom_range(0, 63)));
        else it = cmd_item(psg_seq_pkg::CMD_DELAY, delay_len());
      end else if (!want_cmd && $urandom_range(0, 99) < 12) begin
        it = tick_item();
        it.opcode = OP_CMD;
        counts = 1'b0;
      end else begin
        it = tick_item();
      end
      send_item(it);
      if (counts) done++;
    end
  endtask

  task automatic test_commands_before_start();
    send_item(cmd_item(psg_seq_pkg::CMD_NOTE, 6'h3F));
    repeat (3) send_item(tick_item());
    send_item(cmd_item(psg_seq_pkg::CMD_NOISE, 6'h00));
    wait_drain();
  endtask

  task automatic test_directed_commands();
    psg_seq_pkg::in_item_t it;
    write_reg(psg_seq_pkg::CFG_DECAY_PERIOD, {2'b11, 6'd1});
    write_reg(psg_seq_pkg::CFG_SOFT_NOISE_LEVEL, {4'hA, 4'd15});
    write_reg(psg_seq_pkg::CFG_START_DELAY, 8'd0);
    send_item(tick_item());
    it = cmd_item(psg_seq_pkg::CMD_NOTE, 6'd0);
    it.note_period = 10'd0;
    send_item(it);
    it = cmd_item(psg_seq_pkg::CMD_NOTE, 6'h3F);
    it.note_period = 10'h3FF;
    send_item(it);
    send_item(cmd_item(psg_seq_pkg::CMD_NOTE, 6'h15));
    // all three voices loud: tie goes to voice 0
    send_item(cmd_item(psg_seq_pkg::CMD_NOTE, 6'h2A));
    send_item(cmd_item(psg_seq_pkg::CMD_NOISE, 6'h3F));
    send_item(cmd_item(psg_seq_pkg::CMD_NOISE, 6'h00));
    send_item(tick_item());
    send_item(tick_item());
    // zero delay keeps asking
    send_item(cmd_item(psg_seq_pkg::CMD_DELAY, 6'd0));
    send_item(cmd_item(psg_seq_pkg::CMD_NOTE, 6'h01));
    send_item(cmd_item(psg_seq_pkg::CMD_DELAY, 6'd3));
    send_item(cmd_item(psg_seq_pkg::CMD_NOTE, 6'h02));
    repeat (5) send_item(tick_item());
    send_item(cmd_item(psg_seq_pkg::CMD_NOISE, 6'h28));
    send_item(cmd_item(psg_seq_pkg::CMD_NOISE, 6'h10));
    wait_drain();
  endtask

  task automatic test_random_settings();
    write_reg(psg_seq_pkg::CFG_DECAY_PERIOD, {2'($urandom), 6'd6});
    write_reg(psg_seq_pkg::CFG_SOFT_NOISE_LEVEL, {4'($urandom), 4'd4});
    run_random(50, 25);
    wait_drain();
    write_reg(psg_seq_pkg::CFG_DECAY_PERIOD, {2'($urandom), 6'd1});
    write_reg(psg_seq_pkg::CFG_SOFT_NOISE_LEVEL, {4'($urandom), 4'd15});
    run_random(45, 25);
    wait_drain();
    write_reg(psg_seq_pkg::CFG_DECAY_PERIOD, {2'($urandom), 6'd63});
    write_reg(psg_seq_pkg::CFG_SOFT_NOISE_LEVEL, {4'($urandom), 4'd0});
    run_random(40, 25);
    wait_drain();
    // zero period: decay only when the count wraps
    write_reg(psg_seq_pkg::CFG_DECAY_PERIOD, {2'($urandom), 6'd0});
    write_reg(CFG_UNUSED, 8'($urandom));
    write_reg(psg_seq_pkg::CFG_SOFT_NOISE_LEVEL, 8'($urandom));
    run_random(55, 70);
    wait_drain();
  endtask

  task automatic test_backpressure();
    write_reg(psg_seq_pkg::CFG_DECAY_PERIOD, {2'($urandom), 6'd2});
    hold_left = 400;
    run_random(30, 25);
    wait_drain();
  endtask

  task automatic test_long_start_delay();
    while (!want_cmd) send_item(tick_item());
    send_item(cmd_item(psg_seq_pkg::CMD_DELAY, 6'd5));
    wait_drain();
    write_reg(psg_seq_pkg::CFG_START_DELAY, 8'd120);
    while (!want_cmd) send_item(tick_item());
    wait_drain();
  endtask

  task automatic test_song_end();
    idling_on = 1'b0;
    write_reg(psg_seq_pkg::CFG_DECAY_PERIOD, {2'($urandom), 6'd6});
    write_reg(psg_seq_pkg::CFG_SOFT_NOISE_LEVEL, 8'($urandom));
    run_random(50, 25);
    while (!want_cmd) send_item(tick_item());
    send_item(cmd_item(psg_seq_pkg::CMD_END, 6'($urandom_range(0, 63))));
    // everything after the end is inert
    send_item(tick_item());
    send_item(cmd_item(psg_seq_pkg::CMD_NOTE, 6'h00));
    send_item(tick_item());
    send_item(cmd_item(psg_seq_pkg::CMD_END, 6'h3F));
    wait_drain();
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    reset_mirror();
    repeat (3) @(negedge clk);
    rst = 1'b0;
    test_commands_before_start();
    test_directed_commands();
    test_random_settings();
    test_backpressure();
    test_long_start_delay();
    test_song_end();
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #10000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random stall bursts plus a requested long hold-off
  initial begin : result_sink
    int burst;
    burst = 0;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (burst > 0) begin
        out_ready = 1'b0;
        burst--;
      end else if (idling_on && $urandom_range(0, 99) < 8) begin
        out_ready = 1'b0;
        burst = $urandom_range(0, 15);
      end else begin
        out_ready = 1'b1;
      end
      @(negedge clk);
    end
  end

  task automatic compare_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    psg_seq_pkg::out_item_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result transfer with nothing expected: %p", out_data);
        error_count++;
      end else begin
        exp_r = due_results.pop_front();
        compare_field("has_write", exp_r.has_write, out_data.has_write);
        compare_field("chip_byte", exp_r.chip_byte, out_data.chip_byte);
        compare_field("led_update", exp_r.led_update, out_data.led_update);
        compare_field("led_select", exp_r.led_select, out_data.led_select);
        compare_field("led_level", exp_r.led_level, out_data.led_level);
        compare_field("wants_command", exp_r.wants_command, out_data.wants_command);
        compare_field("song_over", exp_r.song_over, out_data.song_over);
        compare_field("last_of_run", exp_r.last_of_run, out_data.last_of_run);
      end
    end
  end

endmodule
